// ===== hw/rtl/afs_pkg.sv =====
// Shared types, request codes and the frame write rule of the animation frame sequencer.
`timescale 1ns / 1ps

package afs_pkg;

    localparam int FRAME_W = 24;
    localparam int SPEED_W = 16;
    localparam int TIME_W  = 16;
    localparam int REQ_W   = 3;
    localparam int SUM_W   = FRAME_W + 2;
    localparam int PROD_W  = SPEED_W + TIME_W + 1;
    localparam int DELTA_W = PROD_W - 12;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam logic [FRAME_W-1:0] ONE_Q8    = 24'd256;
    localparam logic [FRAME_W-1:0] FRAME_MAX = 24'hFFFFFF;

    localparam logic [REQ_W-1:0] REQ_TICK      = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PLAY_ONCE = 3'd1;
    localparam logic [REQ_W-1:0] REQ_PLAY_LOOP = 3'd2;
    localparam logic [REQ_W-1:0] REQ_STOP      = 3'd3;
    localparam logic [REQ_W-1:0] REQ_PAUSE     = 3'd4;
    localparam logic [REQ_W-1:0] REQ_RESUME    = 3'd5;
    localparam logic [REQ_W-1:0] REQ_SET_FRAME = 3'd6;

    localparam logic [1:0] REG_START = 2'd0;
    localparam logic [1:0] REG_END   = 2'd1;
    localparam logic [1:0] REG_SPEED = 2'd2;

    typedef struct packed {
        logic [FRAME_W-1:0]        start_frame;
        logic [FRAME_W-1:0]        end_frame;
        logic signed [SPEED_W-1:0] frame_speed;
    } afs_cfg_t;

    typedef struct packed {
        logic [FRAME_W-1:0]        position;
        logic [FRAME_W-1:0]        run_start;
        logic [FRAME_W-1:0]        run_end;
        logic signed [SPEED_W-1:0] run_speed;
        logic                      looping;
        logic                      paused;
    } afs_state_t;

    localparam afs_state_t STATE_RESET = '{
        position:  ONE_Q8,
        run_start: '0,
        run_end:   '0,
        run_speed: '0,
        looping:   1'b0,
        paused:    1'b0
    };

    function automatic logic is_active(input afs_state_t st);
        return st.run_end >= ONE_Q8;
    endfunction

    // Clamp a requested frame to 1.0 and the range, then to the run window
    // when a run is live or paused; a looping run wraps past end+1.0 to its start.
    function automatic logic [FRAME_W-1:0] write_frame(
        input logic signed [SUM_W-1:0] f,
        input afs_state_t              st
    );
        logic signed [SUM_W-1:0] v;
        logic signed [SUM_W-1:0] s;
        logic signed [SUM_W-1:0] e;
        v = f;
        s = $signed({2'b00, st.run_start});
        e = $signed({2'b00, st.run_end});
        if (v < $signed({2'b00, ONE_Q8}))
            v = $signed({2'b00, ONE_Q8});
        if (v > $signed({2'b00, FRAME_MAX}))
            v = $signed({2'b00, FRAME_MAX});
        if (is_active(st) || st.paused)
        begin
            if (v < s)
                v = s;
            if (st.looping)
            begin
                if (v > e + $signed({2'b00, ONE_Q8}))
                    v = s;
            end
            else if (v > e)
            begin
                v = e;
            end
        end
        return v[FRAME_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/afs_cfg_regs.sv =====
// APB register file: start frame, end frame and speed.
`timescale 1ns / 1ps

module afs_cfg_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [afs_pkg::ADDR_W-1:0]   paddr,
    input  logic [afs_pkg::DATA_W-1:0]   pwdata,
    output logic [afs_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output afs_pkg::afs_cfg_t            cfg
);
    import afs_pkg::*;

    afs_cfg_t   cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_frame <= ONE_Q8;
            cfg_reg.end_frame   <= '0;
            cfg_reg.frame_speed <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_START: cfg_reg.start_frame <= pwdata[FRAME_W-1:0];
                REG_END:   cfg_reg.end_frame   <= pwdata[FRAME_W-1:0];
                REG_SPEED: cfg_reg.frame_speed <= $signed(pwdata[SPEED_W-1:0]);
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_START: prdata = {8'd0, cfg_reg.start_frame};
            REG_END:   prdata = {8'd0, cfg_reg.end_frame};
            REG_SPEED: prdata = {16'd0, cfg_reg.frame_speed};
            default:   prdata = '0;
        endcase
    end

endmodule

// ===== hw/rtl/afs_step.sv =====
// Next-state logic for one command: tick advance, play, stop, pause, resume, set frame.
`timescale 1ns / 1ps

module afs_step (
    input  afs_pkg::afs_state_t           state_cur,
    input  afs_pkg::afs_cfg_t             cfg,
    input  logic [afs_pkg::REQ_W-1:0]     req_type,
    input  logic [afs_pkg::TIME_W-1:0]    elapsed,
    input  logic [afs_pkg::FRAME_W-1:0]   new_frame,
    output afs_pkg::afs_state_t           state_next,
    output logic                          frame_set
);
    import afs_pkg::*;

    logic signed [PROD_W-1:0]  prod;
    logic signed [DELTA_W-1:0] delta;
    logic signed [SUM_W-1:0]   sum;
    logic signed [SUM_W-1:0]   end_lim;
    logic [FRAME_W-1:0]        once_start;
    logic [FRAME_W-1:0]        once_end;
    afs_state_t                win;

    // Q8.8 * Q4.12 gives Q12.20; taking bits 12 and up floors it to a Q13.8 delta
    assign prod    = $signed(state_cur.run_speed) * $signed({1'b0, elapsed});
    assign delta   = prod[PROD_W-1:12];
    assign sum     = $signed({2'b00, state_cur.position})
                   + $signed({{(SUM_W-DELTA_W){delta[DELTA_W-1]}}, delta});
    assign end_lim = $signed({2'b00, state_cur.run_end});

    assign once_start = (cfg.start_frame < ONE_Q8) ? ONE_Q8 : cfg.start_frame;
    assign once_end   = (cfg.end_frame < once_start) ? once_start : cfg.end_frame;

    always_comb
    begin
        state_next = state_cur;
        frame_set  = 1'b0;
        win        = state_cur;
        unique case (req_type)
            REQ_TICK:
            begin
                if (state_cur.run_end > ONE_Q8 && !state_cur.paused)
                begin
                    frame_set = 1'b1;
                    if (state_cur.looping)
                    begin
                        if (sum > end_lim + $signed({2'b00, ONE_Q8}))
                            state_next.position = write_frame(
                                $signed({2'b00, state_cur.run_start}), state_cur);
                        else
                            state_next.position = write_frame(sum, state_cur);
                    end
                    else
                    begin
                        state_next.position = write_frame(sum, state_cur);
                        if (sum > end_lim)
                        begin
                            state_next.run_start = '0;
                            state_next.run_end   = '0;
                            state_next.run_speed = '0;
                            state_next.looping   = 1'b0;
                            state_next.paused    = 1'b0;
                        end
                    end
                end
            end
            REQ_PLAY_ONCE:
            begin
                // window is at least 1.0 and ordered, so the start needs no clamp
                state_next.run_start = once_start;
                state_next.run_end   = once_end;
                state_next.run_speed = cfg.frame_speed;
                state_next.looping   = 1'b0;
                state_next.paused    = 1'b0;
                state_next.position  = once_start;
                frame_set            = 1'b1;
            end
            REQ_PLAY_LOOP:
            begin
                win.run_start = cfg.start_frame;
                win.run_end   = cfg.end_frame;
                win.run_speed = cfg.frame_speed;
                win.looping   = 1'b1;
                win.paused    = 1'b0;
                state_next    = win;
                state_next.position = write_frame(
                    $signed({2'b00, cfg.start_frame}), win);
                frame_set     = 1'b1;
            end
            REQ_STOP:
            begin
                state_next.run_start = '0;
                state_next.run_end   = '0;
                state_next.run_speed = '0;
                state_next.looping   = 1'b0;
                state_next.paused    = 1'b0;
            end
            REQ_PAUSE:
            begin
                if (is_active(state_cur))
                    state_next.paused = 1'b1;
            end
            REQ_RESUME:
            begin
                if (is_active(state_cur))
                    state_next.paused = 1'b0;
            end
            REQ_SET_FRAME:
            begin
                state_next.position = write_frame($signed({2'b00, new_frame}), state_cur);
                frame_set           = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

// ===== hw/rtl/animation_frame_sequencer.sv =====
// Top level of the animation frame sequencer: input stage, sequencer state, result stage.
`timescale 1ns / 1ps

// Takes one command beat per clock while the output side is not stalled and returns one
// result beat per command, from the input stage through the result registers. The command is
// registered, the next state and result are formed in one pass (a 16x17 multiply,
// a 26-bit add and the window compares) and written to the state and result
// registers together, so a command sees everything its predecessor left. The input
// stays ready while a result waits, until the input stage is also occupied.
// The user must write registers over APB only while no command is in flight (not enforced).

module animation_frame_sequencer (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [afs_pkg::ADDR_W-1:0]   paddr,
    input  logic [afs_pkg::DATA_W-1:0]   pwdata,
    output logic [afs_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [afs_pkg::REQ_W-1:0]    req_type,
    input  logic [afs_pkg::TIME_W-1:0]   elapsed,
    input  logic [afs_pkg::FRAME_W-1:0]  new_frame,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [afs_pkg::FRAME_W-1:0]  frame_pos,
    output logic                         playing,
    output logic                         paused,
    output logic                         frame_set
);
    import afs_pkg::*;

    afs_cfg_t            cfg;
    afs_state_t          state_reg;
    afs_state_t          state_next;
    logic                set_next;

    logic                s1_valid_reg;
    logic [REQ_W-1:0]    s1_req_reg;
    logic [TIME_W-1:0]   s1_elapsed_reg;
    logic [FRAME_W-1:0]  s1_frame_reg;
    logic                s1_advance;

    logic                out_valid_reg;
    logic [FRAME_W-1:0]  out_pos_reg;
    logic                out_playing_reg;
    logic                out_paused_reg;
    logic                out_set_reg;

    afs_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    afs_step u_step (
        .state_cur  (state_reg),
        .cfg        (cfg),
        .req_type   (s1_req_reg),
        .elapsed    (s1_elapsed_reg),
        .new_frame  (s1_frame_reg),
        .state_next (state_next),
        .frame_set  (set_next)
    );

    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_req_reg     <= req_type;
            s1_elapsed_reg <= elapsed;
            s1_frame_reg   <= new_frame;
        end
        if (s1_advance)
        begin
            out_pos_reg     <= state_next.position;
            out_playing_reg <= is_active(state_next) && !state_next.paused;
            out_paused_reg  <= state_next.paused;
            out_set_reg     <= set_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign frame_pos = out_pos_reg;
    assign playing   = out_playing_reg;
    assign paused    = out_paused_reg;
    assign frame_set = out_set_reg;

endmodule

// ===== hw/rtl/afs_checker.sv =====
// Port-level checks for the animation frame sequencer, bound to the top level.
`timescale 1ns / 1ps

module afs_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [afs_pkg::FRAME_W-1:0]  frame_pos,
    input logic                         playing,
    input logic                         paused,
    input logic                         frame_set
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(frame_pos)
            && $stable(playing) && $stable(paused) && $stable(frame_set))
        else $error("result beat changed while stalled");

    a_play_pause: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(playing && paused))
        else $error("playing and paused both set");

    // with no result waiting, the input side must never back-pressure
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input not ready with empty output");

endmodule

bind animation_frame_sequencer afs_checker u_afs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .frame_pos (frame_pos),
    .playing   (playing),
    .paused    (paused),
    .frame_set (frame_set)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the animation frame sequencer: directed and random command beats.

module tb_top;

    import afs_pkg::*;

    localparam logic [REQ_W-1:0] REQ_NOP = 3'd7;
    localparam longint UNIT          = 256;
    localparam longint FRAME_TOP     = 64'hFFFFFF;
    localparam int     CYCLE_LIMIT   = 500000;
    localparam int     HOLD_AT       = 130;
    localparam int     HOLD_CYCLES   = 300;
    localparam int     PHASE_CMDS    = 93;
    localparam int     PHASES        = 10;
    localparam int     DRAIN_CYCLES  = 8;
    localparam int     REPORT_MAX    = 10;

    typedef struct packed {
        logic [REQ_W-1:0]   req;
        logic [TIME_W-1:0]  elapsed;
        logic [FRAME_W-1:0] new_frame;
    } frame_cmd_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame_pos;
        logic               playing;
        logic               paused;
        logic               frame_set;
    } frame_result_t;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 psel      = 1'b0;
    logic                 penable   = 1'b0;
    logic                 pwrite    = 1'b0;
    logic [ADDR_W-1:0]    paddr     = '0;
    logic [DATA_W-1:0]    pwdata    = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic [REQ_W-1:0]     req_type  = '0;
    logic [TIME_W-1:0]    elapsed   = '0;
    logic [FRAME_W-1:0]   new_frame = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [FRAME_W-1:0]   frame_pos;
    logic                 playing;
    logic                 paused;
    logic                 frame_set;

    // register shadows and the predicted sequencer state
    logic [FRAME_W-1:0]        cfg_start = ONE_Q8;
    logic [FRAME_W-1:0]        cfg_end   = '0;
    logic signed [SPEED_W-1:0] cfg_speed = '0;
    logic [FRAME_W-1:0]        seq_pos     = ONE_Q8;
    logic [FRAME_W-1:0]        seq_start   = '0;
    logic [FRAME_W-1:0]        seq_end     = '0;
    logic signed [SPEED_W-1:0] seq_speed   = '0;
    logic                      seq_looping = 1'b0;
    logic                      seq_paused  = 1'b0;

    frame_cmd_t    pending_cmds[$];
    frame_result_t expected_frames[$];
    frame_cmd_t    next_cmd;
    frame_result_t got;
    frame_result_t want;

    int   send_gap       = 0;
    int   recv_gap       = 0;
    int   accepted_total = 0;
    int   result_count   = 0;
    int   error_count    = 0;
    int   cycle_count    = 0;
    logic no_idle        = 1'b0;
    logic hold_off       = 1'b0;

    animation_frame_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .elapsed   (elapsed),
        .new_frame (new_frame),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .frame_pos (frame_pos),
        .playing   (playing),
        .paused    (paused),
        .frame_set (frame_set)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= REPORT_MAX)
            $display("ERROR: %s", msg);
    endtask

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Floor at 1.0 and saturate; inside a live or paused run also pull into the window.
    function automatic logic [FRAME_W-1:0] limit_frame(input longint f);
        longint v;
        longint lo;
        longint hi;
        v  = f;
        lo = seq_start;
        hi = seq_end;
        if (v < UNIT)
            v = UNIT;
        if (v > FRAME_TOP)
            v = FRAME_TOP;
        if (seq_end >= ONE_Q8 || seq_paused)
        begin
            if (v < lo)
                v = lo;
            if (seq_looping)
            begin
                if (v > hi + UNIT)
                    v = lo;
            end
            else if (v > hi)
            begin
                v = hi;
            end
        end
        return v[FRAME_W-1:0];
    endfunction

    task automatic halt_run();
        seq_start   = '0;
        seq_end     = '0;
        seq_speed   = '0;
        seq_paused  = 1'b0;
        seq_looping = 1'b0;
    endtask

    task automatic advance_sequencer(input logic [REQ_W-1:0] req,
                                     input logic [TIME_W-1:0] el,
                                     input logic [FRAME_W-1:0] nf);
        frame_result_t      res;
        longint             pos_l;
        longint             spd_l;
        longint             el_l;
        longint             start_l;
        longint             end_l;
        longint             sum;
        logic [FRAME_W-1:0] first;
        logic [FRAME_W-1:0] last;
        res.frame_set = 1'b0;
        case (req)
            REQ_TICK:
            begin
                if (seq_end > ONE_Q8 && !seq_paused)
                begin
                    pos_l   = seq_pos;
                    spd_l   = seq_speed;
                    el_l    = el;
                    start_l = seq_start;
                    end_l   = seq_end;
                    // Q12.20 product floored to Q16.8
                    sum = pos_l + ((spd_l * el_l) >>> 12);
                    res.frame_set = 1'b1;
                    if (seq_looping)
                        seq_pos = limit_frame((sum > end_l + UNIT) ? start_l : sum);
                    else
                    begin
                        seq_pos = limit_frame(sum);
                        if (sum > end_l)
                            halt_run();
                    end
                end
            end
            REQ_PLAY_ONCE:
            begin
                first       = (cfg_start < ONE_Q8) ? ONE_Q8 : cfg_start;
                last        = (cfg_end < first) ? first : cfg_end;
                seq_start   = first;
                seq_end     = last;
                seq_speed   = cfg_speed;
                seq_looping = 1'b0;
                seq_paused  = 1'b0;
                seq_pos     = limit_frame(first);
                res.frame_set = 1'b1;
            end
            REQ_PLAY_LOOP:
            begin
                seq_start   = cfg_start;
                seq_end     = cfg_end;
                seq_speed   = cfg_speed;
                seq_paused  = 1'b0;
                seq_looping = 1'b1;
                seq_pos     = limit_frame(cfg_start);
                res.frame_set = 1'b1;
            end
            REQ_STOP:
                halt_run();
            REQ_PAUSE:
            begin
                if (seq_end >= ONE_Q8)
                    seq_paused = 1'b1;
            end
            REQ_RESUME:
            begin
                if (seq_end >= ONE_Q8)
                    seq_paused = 1'b0;
            end
            REQ_SET_FRAME:
            begin
                seq_pos = limit_frame(nf);
                res.frame_set = 1'b1;
            end
            default:
            begin
            end
        endcase
        res.frame_pos = seq_pos;
        res.playing   = (seq_end >= ONE_Q8) && !seq_paused;
        res.paused    = seq_paused;
        expected_frames.push_back(res);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        // access phase completes at this edge
        case (idx)
            REG_START: cfg_start = value[FRAME_W-1:0];
            REG_END:   cfg_end   = value[FRAME_W-1:0];
            REG_SPEED: cfg_speed = value[SPEED_W-1:0];
            default:
            begin
            end
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(input logic [FRAME_W-1:0] s, input logic [FRAME_W-1:0] e,
                             input logic [SPEED_W-1:0] spd);
        write_reg(REG_START, DATA_W'(s));
        write_reg(REG_END, DATA_W'(e));
        write_reg(REG_SPEED, DATA_W'(spd));
        @(negedge clk);
    endtask

    task automatic queue_cmd(input logic [REQ_W-1:0] req, input logic [TIME_W-1:0] el,
                             input logic [FRAME_W-1:0] nf);
        frame_cmd_t c;
        c.req       = req;
        c.elapsed   = el;
        c.new_frame = nf;
        pending_cmds.push_back(c);
    endtask

    // Mostly runs: a play followed by ticks with pause, resume, stop, no-op and frame sets mixed in.
    task automatic queue_random_cmds(input int count);
        frame_cmd_t c;
        int         r;
        int         base;
        int         span;
        span = (cfg_end > cfg_start) ? int'(cfg_end - cfg_start) : 0;
        for (int i = 0; i < count; i++)
        begin
            r = (i == 0) ? $urandom_range(0, 13) : $urandom_range(0, 99);
            if (r < 7)
                c.req = REQ_PLAY_ONCE;
            else if (r < 14)
                c.req = REQ_PLAY_LOOP;
            else if (r < 17)
                c.req = REQ_STOP;
            else if (r < 22)
                c.req = REQ_PAUSE;
            else if (r < 27)
                c.req = REQ_RESUME;
            else if (r < 39)
                c.req = REQ_SET_FRAME;
            else if (r < 41)
                c.req = REQ_NOP;
            else
                c.req = REQ_TICK;
            r = $urandom_range(0, 9);
            if (r == 0)
                c.elapsed = '0;
            else if (r == 1)
                c.elapsed = '1;
            else if (r < 6)
                c.elapsed = TIME_W'($urandom_range(0, 16'h2000));
            else
                c.elapsed = TIME_W'($urandom);
            r = $urandom_range(0, 9);
            if (r == 0)
                c.new_frame = '0;
            else if (r == 1)
                c.new_frame = '1;
            else if (r < 7)
            begin
                base = int'(cfg_start) + int'($urandom_range(0, span + 768)) - 384;
                c.new_frame = (base < 0) ? '0 : FRAME_W'(base);
            end
            else
                c.new_frame = FRAME_W'($urandom);
            pending_cmds.push_back(c);
        end
    endtask

    task automatic drain();
        do
        begin
            @(negedge clk);
        end
        while (pending_cmds.size() != 0 || in_valid || expected_frames.size() != 0);
    endtask

    // command driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                advance_sequencer(req_type, elapsed, new_frame);
                accepted_total++;
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap != 0)
                begin
                    in_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (pending_cmds.size() != 0)
                begin
                    next_cmd  = pending_cmds.pop_front();
                    req_type  <= next_cmd.req;
                    elapsed   <= next_cmd.elapsed;
                    new_frame <= next_cmd.new_frame;
                    in_valid  <= 1'b1;
                    send_gap  <= idle_len();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_gap  <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got.frame_pos = frame_pos;
                got.playing   = playing;
                got.paused    = paused;
                got.frame_set = frame_set;
                if (expected_frames.size() == 0)
                    flag_error($sformatf("beat %0d with nothing pending: pos %h pl %b pa %b set %b",
                                         result_count, got.frame_pos, got.playing, got.paused,
                                         got.frame_set));
                else
                begin
                    want = expected_frames.pop_front();
                    if (got !== want)
                        flag_error($sformatf(
                            "beat %0d exp/act: pos %h/%h pl %b/%b pa %b/%b set %b/%b",
                            result_count, want.frame_pos, got.frame_pos, want.playing,
                            got.playing, want.paused, got.paused, want.frame_set,
                            got.frame_set));
                end
                result_count++;
            end
            if (hold_off)
                out_ready <= 1'b0;
            else if (recv_gap != 0)
            begin
                out_ready <= 1'b0;
                recv_gap  <= recv_gap - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                recv_gap  <= idle_len();
            end
        end
    end

    // long receiver stall mid-stream so the input side backs up
    initial
    begin
        wait (accepted_total >= HOLD_AT);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        logic [FRAME_W-1:0] s_cfg;
        logic [FRAME_W-1:0] e_cfg;
        logic [SPEED_W-1:0] v_cfg;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // window 2.0 .. 6.0, speed 1.0
        configure(24'd512, 24'd1536, 16'd256);
        queue_cmd(REQ_TICK, 16'h1000, '0);          // idle tick leaves everything
        queue_cmd(REQ_SET_FRAME, '0, '0);           // below 1.0 while idle
        queue_cmd(REQ_SET_FRAME, '0, '1);
        queue_cmd(REQ_PAUSE, '0, '0);               // no run, ignored
        queue_cmd(REQ_RESUME, '0, '0);
        queue_cmd(REQ_PLAY_ONCE, '0, '0);
        queue_cmd(REQ_TICK, '0, '0);
        queue_cmd(REQ_TICK, 16'h1000, '0);
        queue_cmd(REQ_PAUSE, '0, '0);
        queue_cmd(REQ_TICK, '1, '0);                // paused, no advance
        queue_cmd(REQ_SET_FRAME, '0, '0);           // raised to run start
        queue_cmd(REQ_SET_FRAME, '0, '1);           // clamped to run end
        queue_cmd(REQ_RESUME, '0, '0);
        queue_cmd(REQ_TICK, '1, '0);                // overshoot ends the one-shot run
        queue_cmd(REQ_TICK, '1, '0);
        queue_cmd(REQ_PLAY_LOOP, '0, '0);
        queue_cmd(REQ_TICK, 16'h4000, '0);
        queue_cmd(REQ_TICK, 16'h1000, '0);          // exactly end+1.0 is kept
        queue_cmd(REQ_TICK, 16'h0001, '0);          // sub-frame step floors to zero
        queue_cmd(REQ_TICK, 16'h0010, '0);          // past end+1.0 wraps
        queue_cmd(REQ_SET_FRAME, '0, '1);
        queue_cmd(REQ_NOP, '1, '1);
        queue_cmd(REQ_STOP, '0, '0);
        drain();

        // full window, most negative speed
        configure(ONE_Q8, FRAME_MAX, 16'h8000);
        queue_cmd(REQ_PLAY_ONCE, '0, '0);
        queue_cmd(REQ_TICK, '1, '0);                // sum below zero
        queue_cmd(REQ_SET_FRAME, '0, 24'h800000);
        queue_cmd(REQ_TICK, 16'h0001, '0);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    s_cfg = 24'd256;
                    e_cfg = 24'd2048;
                    v_cfg = 16'd256;
                end
                1:
                begin
                    s_cfg = FRAME_MAX;
                    e_cfg = FRAME_MAX;
                    v_cfg = 16'h7FFF;
                end
                2:
                begin
                    s_cfg = ONE_Q8;
                    e_cfg = FRAME_MAX;
                    v_cfg = 16'h8000;
                end
                3:
                begin
                    s_cfg = 24'd5120;
                    e_cfg = 24'd1024;
                    v_cfg = 16'd128;
                end
                4:
                begin
                    s_cfg = ONE_Q8;
                    e_cfg = '0;
                    v_cfg = 16'd300;
                end
                default:
                begin
                    s_cfg = FRAME_W'($urandom_range(256, 256 * 200));
                    if ($urandom_range(0, 4) == 0)
                        e_cfg = FRAME_W'($urandom_range(0, s_cfg));
                    else
                        e_cfg = s_cfg + FRAME_W'($urandom_range(0, 256 * 40));
                    if ($urandom_range(0, 9) < 7)
                        v_cfg = SPEED_W'($urandom_range(0, 2048) - 1024);
                    else
                        v_cfg = SPEED_W'($urandom);
                end
            endcase
            configure(s_cfg, e_cfg, v_cfg);
            no_idle = ($urandom_range(0, 3) == 0);
            queue_random_cmds(PHASE_CMDS);
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_frames.size() != 0)
            flag_error($sformatf("%0d result beats never arrived", expected_frames.size()));
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
